@@ hw/rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// sit_pkg: shared types for the segment intersection test
// Orientation code of one cross product sign test.
// ----------------------------------------------------------------------------
package sit_pkg;

	// sign of a cross product: zero means the three points are collinear
	typedef enum logic [1:0] {
		ORIENT_COL = 2'd0,
		ORIENT_POS = 2'd1,
		ORIENT_NEG = 2'd2
	} orient_t;

endpackage

@@ hw/rtl/sit_in_if.sv @@
// ----------------------------------------------------------------------------
// sit_in_if: segment pair channel
// Valid/ready channel carrying the endpoints of segments A and B.
// ----------------------------------------------------------------------------
interface sit_in_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] seg_a_start_x;
	logic signed [COORD_WIDTH-1:0] seg_a_start_y;
	logic signed [COORD_WIDTH-1:0] seg_a_end_x;
	logic signed [COORD_WIDTH-1:0] seg_a_end_y;
	logic signed [COORD_WIDTH-1:0] seg_b_start_x;
	logic signed [COORD_WIDTH-1:0] seg_b_start_y;
	logic signed [COORD_WIDTH-1:0] seg_b_end_x;
	logic signed [COORD_WIDTH-1:0] seg_b_end_y;

	modport source (
		output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		       seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		input  ready
	);

	modport sink (
		input  valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
		       seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y,
		output ready
	);
endinterface

@@ hw/rtl/sit_out_if.sv @@
// ----------------------------------------------------------------------------
// sit_out_if: intersection result channel
// Valid/ready channel carrying the one-bit intersection flag.
// ----------------------------------------------------------------------------
interface sit_out_if;
	logic valid;
	logic ready;
	logic intersects;

	modport source (
		output valid, intersects,
		input  ready
	);

	modport sink (
		input  valid, intersects,
		output ready
	);
endinterface

@@ hw/rtl/segment_intersection_test_unit.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_unit: closed segment intersection test
// Four-stage pipeline of orientation tests on two segments per item.
// ----------------------------------------------------------------------------
// in_ch takes one segment pair per item (signed endpoints of A and B), out_ch
// returns one item per pair with the flag intersects, in input order.
// Stages: s1 endpoint differences and bounding box compares, s2 the eight
// cross product multiplies, s3 the four subtracts and their signs, s4 the
// combine into the flag, held in the output register.
// An accepted item passes through s1, s2, s3 and s4 to out_ch.valid. One item
// per cycle is taken while not stalled, with one multiplier per product in s2.
// The whole pipeline advances together; it halts only while the output
// register holds an item the receiver has not taken, and then in_ch.ready
// drops in the same cycle. Nothing is lost or repeated across a stall.
// Reset clears the stage valid bits, so the block comes up empty; the data
// registers are not reset.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit
	import sit_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	sit_in_if.sink      in_ch,
	sit_out_if.source   out_ch
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic signed [PW-1:0]          prod_t;
	typedef logic signed [CW-1:0]          cross_t;

	// pipeline enable: stall only when the output item is not taken
	logic advance;
	assign advance = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = advance;

	// stage 1: differences and bounding box flags
	logic  v_s1;
	diff_t da_x_s1, da_y_s1, dab0_x_s1, dab0_y_s1, dab1_x_s1, dab1_y_s1;
	diff_t db_x_s1, db_y_s1, dba0_x_s1, dba0_y_s1, dba1_x_s1, dba1_y_s1;
	logic [3:0] box_s1;

	coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic [3:0] box_d;

	assign ax0 = in_ch.seg_a_start_x;
	assign ay0 = in_ch.seg_a_start_y;
	assign ax1 = in_ch.seg_a_end_x;
	assign ay1 = in_ch.seg_a_end_y;
	assign bx0 = in_ch.seg_b_start_x;
	assign by0 = in_ch.seg_b_start_y;
	assign bx1 = in_ch.seg_b_end_x;
	assign by1 = in_ch.seg_b_end_y;

	// closed box test of a point against a segment's extent
	function automatic logic in_span(coord_t e0, coord_t m, coord_t e1);
		return (m >= e0 && m <= e1) || (m <= e0 && m >= e1);
	endfunction

	always_comb begin
		box_d[0] = in_span(ax0, bx0, ax1) && in_span(ay0, by0, ay1);
		box_d[1] = in_span(ax0, bx1, ax1) && in_span(ay0, by1, ay1);
		box_d[2] = in_span(bx0, ax0, bx1) && in_span(by0, ay0, by1);
		box_d[3] = in_span(bx0, ax1, bx1) && in_span(by0, ay1, by1);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			da_x_s1   <= DW'(ax1) - DW'(ax0);
			da_y_s1   <= DW'(ay1) - DW'(ay0);
			dab0_x_s1 <= DW'(bx0) - DW'(ax0);
			dab0_y_s1 <= DW'(by0) - DW'(ay0);
			dab1_x_s1 <= DW'(bx1) - DW'(ax0);
			dab1_y_s1 <= DW'(by1) - DW'(ay0);
			db_x_s1   <= DW'(bx1) - DW'(bx0);
			db_y_s1   <= DW'(by1) - DW'(by0);
			dba0_x_s1 <= DW'(ax0) - DW'(bx0);
			dba0_y_s1 <= DW'(ay0) - DW'(by0);
			dba1_x_s1 <= DW'(ax1) - DW'(bx0);
			dba1_y_s1 <= DW'(ay1) - DW'(by0);
			box_s1    <= box_d;
		end
	end

	// stage 2: cross product terms
	logic  v_s2;
	prod_t p1l_s2, p1r_s2, p2l_s2, p2r_s2, p3l_s2, p3r_s2, p4l_s2, p4r_s2;
	logic [3:0] box_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			p1l_s2 <= PW'(da_x_s1) * PW'(dab0_y_s1);
			p1r_s2 <= PW'(da_y_s1) * PW'(dab0_x_s1);
			p2l_s2 <= PW'(da_x_s1) * PW'(dab1_y_s1);
			p2r_s2 <= PW'(da_y_s1) * PW'(dab1_x_s1);
			p3l_s2 <= PW'(db_x_s1) * PW'(dba0_y_s1);
			p3r_s2 <= PW'(db_y_s1) * PW'(dba0_x_s1);
			p4l_s2 <= PW'(db_x_s1) * PW'(dba1_y_s1);
			p4r_s2 <= PW'(db_y_s1) * PW'(dba1_x_s1);
			box_s2 <= box_s1;
		end
	end

	// stage 3: cross products reduced to orientation codes
	logic    v_s3;
	orient_t o1_s3, o2_s3, o3_s3, o4_s3;
	logic [3:0] box_s3;

	function automatic orient_t orient_of(prod_t pl, prod_t pr);
		cross_t cr;
		cr = CW'(pl) - CW'(pr);
		if (cr == '0)
			return ORIENT_COL;
		return cr[CW-1] ? ORIENT_NEG : ORIENT_POS;
	endfunction

	always_ff @(posedge clk) begin
		if (advance) begin
			o1_s3  <= orient_of(p1l_s2, p1r_s2);
			o2_s3  <= orient_of(p2l_s2, p2r_s2);
			o3_s3  <= orient_of(p3l_s2, p3r_s2);
			o4_s3  <= orient_of(p4l_s2, p4r_s2);
			box_s3 <= box_s2;
		end
	end

	// stage 4: general crossing or collinear touch, into the output register
	logic v_s4;
	logic hit_s4;
	logic hit_d;

	always_comb begin
		hit_d = ((o1_s3 != o2_s3) && (o3_s3 != o4_s3))
			|| ((o1_s3 == ORIENT_COL) && box_s3[0])
			|| ((o2_s3 == ORIENT_COL) && box_s3[1])
			|| ((o3_s3 == ORIENT_COL) && box_s3[2])
			|| ((o4_s3 == ORIENT_COL) && box_s3[3]);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s4 <= hit_d;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_ch.valid      = v_s4;
	assign out_ch.intersects = hit_s4;

	// an accepted item enters stage 1
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted item did not enter stage 1");

	// a stalled pipeline keeps the valid bits of stages 1 to 3
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable({v_s1, v_s2, v_s3}))
		else $error("pipeline moved during a stall");

	// a proper crossing in stage 3 gives a set flag
	a_cross_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && v_s3 && (o1_s3 != o2_s3) && (o3_s3 != o4_s3))
		|=> (out_ch.valid && out_ch.intersects))
		else $error("crossing segments not flagged");

endmodule

@@ tb/segment_intersection_test_unit_tb.sv @@
// ----------------------------------------------------------------------------
// segment_intersection_test_unit_tb: self-checking bench for the segment test
// Drives segment pairs through in_ch with random gaps and stalls out_ch at
// random. Each accepted pair gets its flag predicted from exact cross product
// signs, and every flag on out_ch is compared in order with the oldest
// prediction. Directed geometry first, then a mix of random, small-grid,
// collinear, shared-endpoint, point and extreme-coordinate pairs.
// ----------------------------------------------------------------------------
module segment_intersection_test_unit_tb
	import sit_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW          = 16;
	localparam int C_LO        = -(2 ** (CW - 1));
	localparam int C_HI        = (2 ** (CW - 1)) - 1;
	localparam int RANDOM_PAIRS = 1850;
	localparam int CALM_ITEMS  = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic signed [CW-1:0] a_sx;
		logic signed [CW-1:0] a_sy;
		logic signed [CW-1:0] a_ex;
		logic signed [CW-1:0] a_ey;
		logic signed [CW-1:0] b_sx;
		logic signed [CW-1:0] b_sy;
		logic signed [CW-1:0] b_ex;
		logic signed [CW-1:0] b_ey;
	} seg_pair_t;

	typedef struct {
		seg_pair_t pair;
		logic      flag;
	} flag_entry_t;

	logic clk = 1'b0;
	logic arst_n;

	sit_in_if #(.COORD_WIDTH(CW)) seg_ch ();
	sit_out_if flag_ch ();

	segment_intersection_test_unit #(
		.COORD_WIDTH(CW)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (seg_ch.sink),
		.out_ch (flag_ch.source)
	);

	seg_pair_t   pending_pairs[$];
	flag_entry_t awaited_flags[$];
	seg_pair_t   driven_pair;
	int          gap_left;
	int          stall_left;
	int          mismatch_count = 0;
	int          flags_seen = 0;
	int          planned_items;
	int          quiet_cycles = 0;

	// clock
	always #10 clk = ~clk;

	// sign of the cross product (u - o) x (w - o), exact at full width
	function automatic orient_t orientation_of(input logic signed [CW-1:0] ox, oy,
			ux, uy, wx, wy);
		logic signed [CW:0]     dux, duy, dwx, dwy;
		logic signed [2*CW+2:0] cross_prod;
		dux        = ux - ox;
		duy        = uy - oy;
		dwx        = wx - ox;
		dwy        = wy - oy;
		cross_prod = dux * dwy - duy * dwx;
		if (cross_prod == 0)
			return ORIENT_COL;
		return (cross_prod > 0) ? ORIENT_POS : ORIENT_NEG;
	endfunction

	// point m within the closed bounding box of e0..e1
	function automatic logic in_bounds(input logic signed [CW-1:0] e0x, e0y,
			mx, my, e1x, e1y);
		logic signed [CW-1:0] lox, hix, loy, hiy;
		lox = (e0x < e1x) ? e0x : e1x;
		hix = (e0x > e1x) ? e0x : e1x;
		loy = (e0y < e1y) ? e0y : e1y;
		hiy = (e0y > e1y) ? e0y : e1y;
		return (mx >= lox) && (mx <= hix) && (my >= loy) && (my <= hiy);
	endfunction

	function automatic logic predict_intersects(input seg_pair_t p);
		orient_t o1, o2, o3, o4;
		o1 = orientation_of(p.a_sx, p.a_sy, p.a_ex, p.a_ey, p.b_sx, p.b_sy);
		o2 = orientation_of(p.a_sx, p.a_sy, p.a_ex, p.a_ey, p.b_ex, p.b_ey);
		o3 = orientation_of(p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_sx, p.a_sy);
		o4 = orientation_of(p.b_sx, p.b_sy, p.b_ex, p.b_ey, p.a_ex, p.a_ey);
		if (o1 != o2 && o3 != o4)
			return 1'b1;
		// collinear endpoint lying on the other segment
		if (o1 == ORIENT_COL && in_bounds(p.a_sx, p.a_sy, p.b_sx, p.b_sy, p.a_ex, p.a_ey))
			return 1'b1;
		if (o2 == ORIENT_COL && in_bounds(p.a_sx, p.a_sy, p.b_ex, p.b_ey, p.a_ex, p.a_ey))
			return 1'b1;
		if (o3 == ORIENT_COL && in_bounds(p.b_sx, p.b_sy, p.a_sx, p.a_sy, p.b_ex, p.b_ey))
			return 1'b1;
		if (o4 == ORIENT_COL && in_bounds(p.b_sx, p.b_sy, p.a_ex, p.a_ey, p.b_ex, p.b_ey))
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic seg_pair_t make_pair(input int ax0, ay0, ax1, ay1,
			bx0, by0, bx1, by1);
		seg_pair_t p;
		p.a_sx = CW'(ax0);
		p.a_sy = CW'(ay0);
		p.a_ex = CW'(ax1);
		p.a_ey = CW'(ay1);
		p.b_sx = CW'(bx0);
		p.b_sy = CW'(by0);
		p.b_ex = CW'(bx1);
		p.b_ey = CW'(by1);
		return p;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 6))
			0: return C_LO;
			1: return C_HI;
			2: return 0;
			3: return -1;
			4: return 1;
			5: return C_LO + 1;
			default: return C_HI - 1;
		endcase
	endfunction

	// one random pair, weighted toward touching and collinear geometry
	function automatic seg_pair_t random_pair();
		int c[8];
		int kind, bx, by, dx, dy, k, pt;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2: begin
				for (int i = 0; i < 8; i++)
					c[i] = int'($urandom);
			end
			3, 4: begin
				for (int i = 0; i < 8; i++)
					c[i] = int'($urandom_range(0, 16)) - 8;
			end
			5, 6: begin
				// four points on one line, sometimes one nudged off it
				bx = int'($urandom_range(0, 2000)) - 1000;
				by = int'($urandom_range(0, 2000)) - 1000;
				dx = int'($urandom_range(0, 40)) - 20;
				dy = int'($urandom_range(0, 40)) - 20;
				for (int i = 0; i < 4; i++) begin
					k = int'($urandom_range(0, 12)) - 6;
					c[2*i]   = bx + k * dx;
					c[2*i+1] = by + k * dy;
				end
				if ($urandom_range(0, 3) == 0) begin
					pt = $urandom_range(0, 7);
					c[pt] = c[pt] + (($urandom_range(0, 1) == 0) ? 1 : -1);
				end
			end
			7: begin
				// B starts on one of A's endpoints
				for (int i = 0; i < 8; i++)
					c[i] = ($urandom_range(0, 1) == 0) ? int'($urandom)
						: int'($urandom_range(0, 64)) - 32;
				pt = 2 * $urandom_range(0, 1);
				c[4] = c[pt];
				c[5] = c[pt+1];
			end
			8: begin
				// a point segment near a line segment
				bx = int'($urandom_range(0, 2000)) - 1000;
				by = int'($urandom_range(0, 2000)) - 1000;
				dx = int'($urandom_range(0, 16)) - 8;
				dy = int'($urandom_range(0, 16)) - 8;
				k  = int'($urandom_range(0, 8));
				c[0] = bx;
				c[1] = by;
				c[2] = bx + k * dx;
				c[3] = by + k * dy;
				k  = int'($urandom_range(0, 12)) - 2;
				c[4] = bx + k * dx + (($urandom_range(0, 3) == 0) ? 1 : 0);
				c[5] = by + k * dy;
				c[6] = c[4];
				c[7] = c[5];
				if ($urandom_range(0, 1) == 0) begin
					// swap roles so A is the point
					for (int i = 0; i < 4; i++) begin
						pt = c[i];
						c[i] = c[i+4];
						c[i+4] = pt;
					end
				end
			end
			default: begin
				for (int i = 0; i < 8; i++)
					c[i] = pick_extreme();
			end
		endcase
		return make_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// driver: one item on in_ch, with random gaps after acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_ch.valid         <= 1'b0;
			seg_ch.seg_a_start_x <= '0;
			seg_ch.seg_a_start_y <= '0;
			seg_ch.seg_a_end_x   <= '0;
			seg_ch.seg_a_end_y   <= '0;
			seg_ch.seg_b_start_x <= '0;
			seg_ch.seg_b_start_y <= '0;
			seg_ch.seg_b_end_x   <= '0;
			seg_ch.seg_b_end_y   <= '0;
			gap_left             <= 0;
		end else begin
			// accepted item gets its flag predicted
			if (seg_ch.valid && seg_ch.ready)
				awaited_flags.push_back('{pair: driven_pair,
					flag: predict_intersects(driven_pair)});
			if (!seg_ch.valid || seg_ch.ready) begin
				if (gap_left > 0) begin
					seg_ch.valid <= 1'b0;
					gap_left     <= gap_left - 1;
				end else if (pending_pairs.size() > 0) begin
					driven_pair          <= pending_pairs[0];
					seg_ch.seg_a_start_x <= pending_pairs[0].a_sx;
					seg_ch.seg_a_start_y <= pending_pairs[0].a_sy;
					seg_ch.seg_a_end_x   <= pending_pairs[0].a_ex;
					seg_ch.seg_a_end_y   <= pending_pairs[0].a_ey;
					seg_ch.seg_b_start_x <= pending_pairs[0].b_sx;
					seg_ch.seg_b_start_y <= pending_pairs[0].b_sy;
					seg_ch.seg_b_end_x   <= pending_pairs[0].b_ex;
					seg_ch.seg_b_end_y   <= pending_pairs[0].b_ey;
					seg_ch.valid         <= 1'b1;
					void'(pending_pairs.pop_front());
					if (pending_pairs.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
						gap_left <= $urandom_range(1, 7);
				end else begin
					seg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each flag against the oldest prediction, stall at random
	always @(posedge clk or negedge arst_n) begin
		flag_entry_t want;
		if (!arst_n) begin
			flag_ch.ready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (flag_ch.valid && flag_ch.ready) begin
				flags_seen++;
				if (awaited_flags.size() == 0) begin
					report_mismatch($sformatf("flag %0b with no item outstanding",
						flag_ch.intersects));
				end else begin
					want = awaited_flags.pop_front();
					if (flag_ch.intersects !== want.flag)
						report_mismatch($sformatf(
							"A (%0d,%0d)-(%0d,%0d) B (%0d,%0d)-(%0d,%0d) got %b want %b",
							want.pair.a_sx, want.pair.a_sy, want.pair.a_ex, want.pair.a_ey,
							want.pair.b_sx, want.pair.b_sy, want.pair.b_ex, want.pair.b_ey,
							flag_ch.intersects, want.flag));
				end
			end
			if (stall_left > 0) begin
				flag_ch.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (flags_seen < planned_items - CALM_ITEMS
					&& $urandom_range(0, 7) == 0) begin
				flag_ch.ready <= 1'b0;
				stall_left    <= $urandom_range(0, 6);
			end else begin
				flag_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (seg_ch.valid && seg_ch.ready) || (flag_ch.valid && flag_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("segment_intersection_test_unit_tb: FAIL");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		arst_n = 1'b0;

		// directed geometry
		pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
		pending_pairs.push_back(make_pair(10, 10, 0, 0, 10, 0, 0, 10));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 15, 0));
		pending_pairs.push_back(make_pair(0, 0, 4, 0, 5, 0, 9, 0));
		pending_pairs.push_back(make_pair(0, 0, 5, 0, 5, 0, 9, 0));
		pending_pairs.push_back(make_pair(0, 0, 20, 0, 5, 0, 6, 0));
		pending_pairs.push_back(make_pair(3, -5, 3, 5, 3, 4, 3, 9));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
		pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 7));
		pending_pairs.push_back(make_pair(0, 0, 2, 2, 10, 0, 0, 10));
		pending_pairs.push_back(make_pair(0, 0, 6, 6, 3, 3, 3, 3));
		pending_pairs.push_back(make_pair(0, 0, 6, 6, 3, 4, 3, 4));
		pending_pairs.push_back(make_pair(0, 0, 6, 6, 7, 7, 7, 7));
		pending_pairs.push_back(make_pair(4, 4, 4, 4, 0, 0, 6, 6));
		pending_pairs.push_back(make_pair(2, -3, 2, -3, 2, -3, 2, -3));
		pending_pairs.push_back(make_pair(1, 1, 1, 1, 2, 2, 2, 2));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
		pending_pairs.push_back(make_pair(C_LO, C_LO, C_HI, C_HI, C_LO, C_HI, C_HI, C_LO));
		pending_pairs.push_back(make_pair(C_LO, C_LO, C_HI, C_LO, C_LO, C_HI, C_HI, C_HI));
		pending_pairs.push_back(make_pair(C_LO, C_LO, C_HI, C_HI, -1, -1, 0, 0));
		pending_pairs.push_back(make_pair(C_LO, C_LO, C_HI, C_HI, C_LO, C_LO + 1,
			C_HI - 1, C_HI));
		pending_pairs.push_back(make_pair(C_HI, C_LO, C_LO, C_HI, C_HI, C_HI, C_LO, C_LO));

		// random pairs
		for (int i = 0; i < RANDOM_PAIRS; i++)
			pending_pairs.push_back(random_pair());
		planned_items = pending_pairs.size();

		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		// wait for all items to go in and all flags to come back
		while (pending_pairs.size() > 0 || seg_ch.valid)
			@(posedge clk);
		while (awaited_flags.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && awaited_flags.size() == 0) begin
			$display("segment_intersection_test_unit_tb: PASS");
		end else begin
			$display("segment_intersection_test_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

@@ segment_intersection_test_unit.f @@
hw/rtl/sit_pkg.sv
hw/rtl/sit_in_if.sv
hw/rtl/sit_out_if.sv
hw/rtl/segment_intersection_test_unit.sv
tb/segment_intersection_test_unit_tb.sv
